>>> src/fsbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsbc_pkg
// Shared types and constants for the flat shading / back-face cull pipeline.
// ----------------------------------------------------------------------------
package fsbc_pkg;

    localparam int COORD_W   = 16;   // vertex and register coordinate width
    localparam int COLOR_W   = 8;
    localparam int AMB_W     = 9;
    localparam int COS_FRAC  = 16;   // cosine fraction bits
    localparam int COS_W     = COS_FRAC + 1;   // cosine in [0, 1.0]
    localparam int QUO_W     = 2 * COS_FRAC + 1; // cos^2 scaled, up to 1.0
    localparam int PROD_W    = 100;  // |L|^2*|N|^2 and dot^2 magnitude width
    localparam int DIV_STEPS = QUO_W;
    localparam int SQRT_STEPS = COS_W;
    localparam int NUM_W     = COS_FRAC + 9; // shade factor, up to 2^(C+8)

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_PROJ_Z  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT_X = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT_Y = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT_Z = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_AMBIENT = 3'd4;

    // per-item control that rides alongside the cosine datapath
    typedef struct packed {
        logic               visible;
        logic               lit;
        logic [AMB_W-1:0]   amb;
        logic [COLOR_W-1:0] col_r;
        logic [COLOR_W-1:0] col_g;
        logic [COLOR_W-1:0] col_b;
    } side_t;

endpackage

>>> src/fsbc_cos_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsbc_cos_unit
// Pipelined |cos| = isqrt(floor(num * 2^(2C) / den)): one quotient bit per
// stage, then one root bit per stage.
// ----------------------------------------------------------------------------
module fsbc_cos_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire fsbc_pkg::side_t               in_side,
    input  wire logic [fsbc_pkg::PROD_W-1:0]   in_num,   // dot^2
    input  wire logic [fsbc_pkg::PROD_W-1:0]   in_den,   // |L|^2 * |N|^2
    output logic                               out_valid,
    output fsbc_pkg::side_t                    out_side,
    output logic [fsbc_pkg::COS_W-1:0]         out_cos
);

    localparam int DIV_N = fsbc_pkg::DIV_STEPS;
    localparam int SQ_N  = fsbc_pkg::SQRT_STEPS;
    localparam int LAT   = DIV_N + SQ_N;
    localparam int PW    = fsbc_pkg::PROD_W;
    localparam int QW    = fsbc_pkg::QUO_W;
    localparam int CW    = fsbc_pkg::COS_W;

    logic            v_reg    [0:LAT];
    fsbc_pkg::side_t side_reg [0:LAT];
    logic [PW-1:0]   rem_reg  [0:DIV_N];
    logic [PW-1:0]   den_reg  [0:DIV_N];
    logic [QW-1:0]   quo_reg  [0:DIV_N];
    logic            lsb_reg;
    logic [QW-1:0]   rad_reg  [1:SQ_N];
    logic [CW-1:0]   root_reg [1:SQ_N];

    // entry: dividend is num * 2^(2C); its top part is num >> 1, which is
    // already below den, so only the low QW dividend bits are left to shift in
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            rem_reg[0]  <= in_num >> 1;
            den_reg[0]  <= in_den;
            quo_reg[0]  <= '0;
            lsb_reg     <= in_num[0];
        end
    end

    genvar i, j;
    generate
        for (i = 0; i < LAT; i++) begin : g_ctl
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[i+1] <= 1'b0;
                end else if (en) begin
                    v_reg[i+1] <= v_reg[i];
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    side_reg[i+1] <= side_reg[i];
                end
            end
        end

        for (i = 0; i < DIV_N; i++) begin : g_div
            logic          bit_in;
            logic [PW:0]   trial;
            logic [PW:0]   diff;
            logic          take;
            if (i == 0) begin : g_first
                assign bit_in = lsb_reg;
            end else begin : g_rest
                assign bit_in = 1'b0;
            end
            assign trial = {rem_reg[i], bit_in};
            assign take  = (trial >= {1'b0, den_reg[i]});
            assign diff  = trial - {1'b0, den_reg[i]};
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i+1] <= take ? diff[PW-1:0] : trial[PW-1:0];
                    den_reg[i+1] <= den_reg[i];
                    quo_reg[i+1] <= {quo_reg[i][QW-2:0], take};
                end
            end
        end

        for (j = 0; j < SQ_N; j++) begin : g_sqrt
            logic [QW-1:0]   rad_in;
            logic [CW-1:0]   root_in;
            logic [CW-1:0]   trial;
            logic [2*CW-1:0] sq;
            logic            fits;
            if (j == 0) begin : g_first
                assign rad_in  = quo_reg[DIV_N];
                assign root_in = '0;
            end else begin : g_rest
                assign rad_in  = rad_reg[j];
                assign root_in = root_reg[j];
            end
            assign trial = root_in | (CW'(1) << (SQ_N - 1 - j));
            assign sq    = trial * trial;
            assign fits  = (sq <= (2*CW)'(rad_in));
            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[j+1]  <= rad_in;
                    root_reg[j+1] <= fits ? trial : root_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[LAT];
    assign out_side  = side_reg[LAT];
    assign out_cos   = root_reg[SQ_N];

endmodule
`default_nettype wire

>>> src/flat_shade_backface_cull.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flat_shade_backface_cull
// Back-face cull and flat Lambert shading of one triangle per item.
// ----------------------------------------------------------------------------
// Fully pipelined: one triangle is accepted every cycle while the skid is
// empty; its result shows on m_tvalid after 7 geometry stages, 51 stages of
// the bit-per-stage divider and square root that form |cos|, 2 shading stages
// and 1 output register. The normal is cross(A0A2, A0A1); the face is visible
// when dot(A0 - P, N) > 0 with P = (0, 0, projection_z), and lit when
// dot(L, N) < 0. Lit: factor = k + (1-k)*|cos|, cos with 16 fraction bits,
// exact (truncated); unlit: factor = k; culled faces return all zeros.
// k = ambient_level/256, values above 256 act as 256. A two-entry output
// register plus skid keeps s_tready registered; the whole pipe holds only
// while the skid is full. Config is static during traffic (write when idle).
// ----------------------------------------------------------------------------
module flat_shade_backface_cull (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // config write port, index = register number
    input  wire logic                               cfg_we,
    input  wire logic [fsbc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [fsbc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input items
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // a0_x, a0_y, a0_z, a1_x, a1_y, a1_z, a2_x, a2_y, a2_z (16 each),
    // color_r, color_g, color_b (8 each)
    input  wire logic [167:0]                       s_tdata,
    // result items
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // shade_r, shade_g, shade_b (8 each)
    output logic [23:0]                             m_tdata,
    // visible, lit
    output logic [1:0]                              m_tuser
);

    // ---------------- config registers ----------------
    logic [15:0] cfg_pz_reg, cfg_lx_reg, cfg_ly_reg, cfg_lz_reg;
    logic [8:0]  cfg_amb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_pz_reg  <= 16'd16000;
            cfg_lx_reg  <= 16'd0;
            cfg_ly_reg  <= 16'd0;
            cfg_lz_reg  <= 16'hF000;   // -4096
            cfg_amb_reg <= 9'd64;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                fsbc_pkg::CFG_PROJ_Z:  cfg_pz_reg  <= cfg_wdata;
                fsbc_pkg::CFG_LIGHT_X: cfg_lx_reg  <= cfg_wdata;
                fsbc_pkg::CFG_LIGHT_Y: cfg_ly_reg  <= cfg_wdata;
                fsbc_pkg::CFG_LIGHT_Z: cfg_lz_reg  <= cfg_wdata;
                fsbc_pkg::CFG_AMBIENT: cfg_amb_reg <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    logic signed [15:0] lx, ly, lz, pz;
    assign lx = $signed(cfg_lx_reg);
    assign ly = $signed(cfg_ly_reg);
    assign lz = $signed(cfg_lz_reg);
    assign pz = $signed(cfg_pz_reg);

    // ---------------- flow control ----------------
    logic en;
    logic skid_full_reg;
    assign en       = !skid_full_reg;
    assign s_tready = en;

    // ---------------- S1: edges ----------------
    logic signed [15:0] a0x, a0y, a0z, a1x, a1y, a1z, a2x, a2y, a2z;
    assign a0x = $signed(s_tdata[15:0]);
    assign a0y = $signed(s_tdata[31:16]);
    assign a0z = $signed(s_tdata[47:32]);
    assign a1x = $signed(s_tdata[63:48]);
    assign a1y = $signed(s_tdata[79:64]);
    assign a1z = $signed(s_tdata[95:80]);
    assign a2x = $signed(s_tdata[111:96]);
    assign a2y = $signed(s_tdata[127:112]);
    assign a2z = $signed(s_tdata[143:128]);

    fsbc_pkg::side_t side_in;
    always_comb begin
        side_in.visible = 1'b0;
        side_in.lit     = 1'b0;
        side_in.amb     = (cfg_amb_reg > 9'd256) ? 9'd256 : cfg_amb_reg;
        side_in.col_r   = s_tdata[151:144];
        side_in.col_g   = s_tdata[159:152];
        side_in.col_b   = s_tdata[167:160];
    end

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    fsbc_pkg::side_t sd1_reg, sd2_reg, sd3_reg, sd4_reg, sd5_reg, sd6_reg, sd7_reg;

    logic signed [16:0] e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    logic signed [15:0] p0x_reg, p0y_reg;
    logic signed [16:0] p0z_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            e1x_reg <= 17'(a2x) - 17'(a0x);
            e1y_reg <= 17'(a2y) - 17'(a0y);
            e1z_reg <= 17'(a2z) - 17'(a0z);
            e2x_reg <= 17'(a1x) - 17'(a0x);
            e2y_reg <= 17'(a1y) - 17'(a0y);
            e2z_reg <= 17'(a1z) - 17'(a0z);
            p0x_reg <= a0x;
            p0y_reg <= a0y;
            p0z_reg <= 17'(a0z) - 17'(pz);
            sd1_reg <= side_in;
        end
    end

    // ---------------- S2: normal = e1 x e2 ----------------
    logic signed [33:0] t1, t2, t3, t4, t5, t6;
    assign t1 = e1y_reg * e2z_reg;
    assign t2 = e2y_reg * e1z_reg;
    assign t3 = e2x_reg * e1z_reg;
    assign t4 = e1x_reg * e2z_reg;
    assign t5 = e1x_reg * e2y_reg;
    assign t6 = e2x_reg * e1y_reg;

    logic signed [34:0] nx_reg, ny_reg, nz_reg;
    logic signed [15:0] q0x_reg, q0y_reg;
    logic signed [16:0] q0z_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg  <= 35'(t1) - 35'(t2);
            ny_reg  <= 35'(t3) - 35'(t4);
            nz_reg  <= 35'(t5) - 35'(t6);
            q0x_reg <= p0x_reg;
            q0y_reg <= p0y_reg;
            q0z_reg <= p0z_reg;
            sd2_reg <= sd1_reg;
        end
    end

    // ---------------- S3: dot and square products ----------------
    logic signed [51:0] vpx, vpy, vpz;
    logic signed [50:0] lpx, lpy, lpz;
    logic [32:0]        nax, nay, naz;
    logic [65:0]        nsx, nsy, nsz;
    logic signed [31:0] lsx, lsy, lsz;

    assign vpx = q0x_reg * nx_reg;
    assign vpy = q0y_reg * ny_reg;
    assign vpz = q0z_reg * nz_reg;
    assign lpx = lx * nx_reg;
    assign lpy = ly * ny_reg;
    assign lpz = lz * nz_reg;
    // |n| stays below 2^33
    assign nax = nx_reg[34] ? 33'(-nx_reg) : 33'(nx_reg);
    assign nay = ny_reg[34] ? 33'(-ny_reg) : 33'(ny_reg);
    assign naz = nz_reg[34] ? 33'(-nz_reg) : 33'(nz_reg);
    assign nsx = nax * nax;
    assign nsy = nay * nay;
    assign nsz = naz * naz;
    assign lsx = lx * lx;
    assign lsy = ly * ly;
    assign lsz = lz * lz;

    logic signed [51:0] vpx_reg, vpy_reg, vpz_reg;
    logic signed [50:0] lpx_reg, lpy_reg, lpz_reg;
    logic [65:0]        nsx_reg, nsy_reg, nsz_reg;
    logic [30:0]        lsx_reg, lsy_reg, lsz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            vpx_reg <= vpx;
            vpy_reg <= vpy;
            vpz_reg <= vpz;
            lpx_reg <= lpx;
            lpy_reg <= lpy;
            lpz_reg <= lpz;
            nsx_reg <= nsx;
            nsy_reg <= nsy;
            nsz_reg <= nsz;
            lsx_reg <= lsx[30:0];
            lsy_reg <= lsy[30:0];
            lsz_reg <= lsz[30:0];
            sd3_reg <= sd2_reg;
        end
    end

    // ---------------- S4: sums, face tests ----------------
    logic signed [53:0] vis;
    logic signed [52:0] ld;
    logic [49:0]        dmag;
    fsbc_pkg::side_t    sd4_next;

    assign vis  = 54'(vpx_reg) + 54'(vpy_reg) + 54'(vpz_reg);
    assign ld   = 53'(lpx_reg) + 53'(lpy_reg) + 53'(lpz_reg);
    assign dmag = ld[52] ? 50'(-ld) : 50'(ld);

    always_comb begin
        sd4_next         = sd3_reg;
        sd4_next.visible = !vis[53] && (vis != '0);
        sd4_next.lit     = sd4_next.visible && ld[52];
    end

    logic [49:0] d_reg;
    logic [67:0] n2_reg;
    logic [31:0] l2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg   <= dmag;
            n2_reg  <= 68'(nsx_reg) + 68'(nsy_reg) + 68'(nsz_reg);
            l2_reg  <= 32'(lsx_reg) + 32'(lsy_reg) + 32'(lsz_reg);
            sd4_reg <= sd4_next;
        end
    end

    // ---------------- S5: dot^2 partial products ----------------
    logic [49:0] phh, phl, pll;
    assign phh = d_reg[49:25] * d_reg[49:25];
    assign phl = d_reg[49:25] * d_reg[24:0];
    assign pll = d_reg[24:0] * d_reg[24:0];

    logic [49:0] phh_reg, phl_reg, pll_reg;
    logic [67:0] n2b_reg;
    logic [31:0] l2b_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            phh_reg <= phh;
            phl_reg <= phl;
            pll_reg <= pll;
            n2b_reg <= n2_reg;
            l2b_reg <= l2_reg;
            sd5_reg <= sd4_reg;
        end
    end

    // ---------------- S6: dot^2 sum, |L|^2*|N|^2 partials ----------------
    logic [65:0] lnlo, lnhi;
    assign lnlo = l2b_reg * n2b_reg[33:0];
    assign lnhi = l2b_reg * n2b_reg[67:34];

    logic [99:0] d2_reg;
    logic [65:0] lnlo_reg, lnhi_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_reg   <= (100'(phh_reg) << 50) + (100'(phl_reg) << 26) + 100'(pll_reg);
            lnlo_reg <= lnlo;
            lnhi_reg <= lnhi;
            sd6_reg  <= sd5_reg;
        end
    end

    // ---------------- S7: |L|^2*|N|^2 ----------------
    logic [99:0] num_reg, den_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg <= d2_reg;
            den_reg <= (100'(lnhi_reg) << 34) + 100'(lnlo_reg);
            sd7_reg <= sd6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // ---------------- cosine: divider + square root ----------------
    logic                          cu_valid;
    fsbc_pkg::side_t               cu_side;
    logic [fsbc_pkg::COS_W-1:0]    cu_cos;

    fsbc_cos_unit u_cos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v7_reg),
        .in_side   (sd7_reg),
        .in_num    (num_reg),
        .in_den    (den_reg),
        .out_valid (cu_valid),
        .out_side  (cu_side),
        .out_cos   (cu_cos)
    );

    // ---------------- F1: shade factor ----------------
    // unlit factor k*2^C gives floor(c*k/256) after the common >> (C+8)
    logic [fsbc_pkg::NUM_W-1:0] amb_sh;
    logic [fsbc_pkg::NUM_W:0]   diff_term;
    assign amb_sh    = {cu_side.amb, {fsbc_pkg::COS_FRAC{1'b0}}};
    assign diff_term = (9'd256 - cu_side.amb) * cu_cos;

    logic                        f1_v_reg, f2_v_reg;
    fsbc_pkg::side_t             f1_sd_reg;
    logic [fsbc_pkg::NUM_W-1:0]  f1_num_reg;
    logic [7:0]                  f2_r_reg, f2_g_reg, f2_b_reg;
    logic                        f2_vis_reg, f2_lit_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_sd_reg  <= cu_side;
            f1_num_reg <= cu_side.lit ? amb_sh + diff_term[fsbc_pkg::NUM_W-1:0] : amb_sh;
        end
    end

    // ---------------- F2: channel scaling ----------------
    localparam int SH = fsbc_pkg::COS_FRAC + 8;
    logic [fsbc_pkg::NUM_W+7:0] pr, pg, pb;
    assign pr = f1_sd_reg.col_r * f1_num_reg;
    assign pg = f1_sd_reg.col_g * f1_num_reg;
    assign pb = f1_sd_reg.col_b * f1_num_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            f2_vis_reg <= f1_sd_reg.visible;
            f2_lit_reg <= f1_sd_reg.lit;
            f2_r_reg   <= f1_sd_reg.visible ? pr[SH+7:SH] : 8'd0;
            f2_g_reg   <= f1_sd_reg.visible ? pg[SH+7:SH] : 8'd0;
            f2_b_reg   <= f1_sd_reg.visible ? pb[SH+7:SH] : 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
        end else if (en) begin
            f1_v_reg <= cu_valid;
            f2_v_reg <= f1_v_reg;
        end
    end

    // ---------------- output register + skid ----------------
    logic [25:0] pipe_item;
    assign pipe_item = {f2_lit_reg, f2_vis_reg, f2_b_reg, f2_g_reg, f2_r_reg};

    logic        out_v_reg;
    logic [25:0] out_reg, skid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg     <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (m_tready || !out_v_reg) begin
            if (skid_full_reg) begin
                out_v_reg     <= 1'b1;
                skid_full_reg <= 1'b0;
            end else begin
                out_v_reg <= f2_v_reg;
            end
        end else if (f2_v_reg) begin
            skid_full_reg <= 1'b1;   // pipe end item parks, pipe holds next cycle
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !out_v_reg) begin
            out_reg <= skid_full_reg ? skid_reg : pipe_item;
        end else if (en && f2_v_reg) begin
            skid_reg <= pipe_item;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg[23:0];
    assign m_tuser  = out_reg[25:24];

`ifndef ASSERT_OFF
    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> out_v_reg)
        else $error("skid holds an item while the output register is empty");

    a_lit_implies_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("lit result on a culled face");

    a_culled_is_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 24'd0)
        else $error("culled face carries a nonzero shade");
`endif

endmodule
`default_nettype wire

>>> tb/fsbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsbc_checker
// Watches config writes and both streams of the cull/shade block, predicts
// every result item and compares it field by field, in order.
// ----------------------------------------------------------------------------
module fsbc_checker (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [fsbc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [fsbc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tready,
    input  wire logic [167:0]                       s_tdata,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [23:0]                        m_tdata,
    input  wire logic [1:0]                         m_tuser,
    output int                                      fail_count,
    output int                                      pending
);

    typedef struct packed {
        logic       visible;
        logic       lit;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } shade_t;

    logic signed [15:0] proj_z, lgt_x, lgt_y, lgt_z;
    logic [8:0]         amb_lvl;
    shade_t             shade_q[$];

    function automatic shade_t shade_face(logic [167:0] d);
        longint c[9];
        longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz, vis, ld, lx, ly, lz;
        longint col[3];
        logic [191:0] rhs, lhs, ln, dd;
        longint lo, hi, mid, amb, num;
        shade_t s;
        for (int i = 0; i < 9; i++) c[i] = longint'($signed(d[16*i +: 16]));
        for (int i = 0; i < 3; i++) col[i] = longint'(d[144 + 8*i +: 8]);
        lx = lgt_x; ly = lgt_y; lz = lgt_z;
        amb = (amb_lvl > 256) ? 256 : amb_lvl;
        e1x = c[6] - c[0]; e1y = c[7] - c[1]; e1z = c[8] - c[2];
        e2x = c[3] - c[0]; e2y = c[4] - c[1]; e2z = c[5] - c[2];
        nx = e1y * e2z - e2y * e1z;
        ny = e2x * e1z - e1x * e2z;
        nz = e1x * e2y - e2x * e1y;
        vis = c[0] * nx + c[1] * ny + (c[2] - longint'(proj_z)) * nz;
        s = '0;
        if (vis <= 0) return s;
        s.visible = 1'b1;
        ld = lx * nx + ly * ny + lz * nz;
        if (ld < 0) begin
            dd  = 192'(-ld);
            rhs = (dd * dd) << (2 * fsbc_pkg::COS_FRAC);
            // |N|^2 reaches 2^67, so it is summed at full width
            ln  = 192'(lx * lx + ly * ly + lz * lz) *
                  (192'(nx) * 192'(nx) + 192'(ny) * 192'(ny) + 192'(nz) * 192'(nz));
            lo = 0; hi = (64'd1 << fsbc_pkg::COS_FRAC) + 1;
            // largest cos with cos^2*|L|^2*|N|^2 <= 2^2C * dot^2
            while (lo + 1 < hi) begin
                mid = lo + (hi - lo) / 2;
                lhs = 192'(mid * mid) * ln;
                if (lhs <= rhs) lo = mid; else hi = mid;
            end
            num = (amb << fsbc_pkg::COS_FRAC) + (256 - amb) * lo;
            s.lit = 1'b1;
            s.r = 8'((col[0] * num) >> (fsbc_pkg::COS_FRAC + 8));
            s.g = 8'((col[1] * num) >> (fsbc_pkg::COS_FRAC + 8));
            s.b = 8'((col[2] * num) >> (fsbc_pkg::COS_FRAC + 8));
        end else begin
            s.r = 8'((col[0] * amb) >> 8);
            s.g = 8'((col[1] * amb) >> 8);
            s.b = 8'((col[2] * amb) >> 8);
        end
        return s;
    endfunction

    assign pending = shade_q.size();

    always @(posedge aclk) begin
        shade_t want, got;
        if (!aresetn) begin
            proj_z  <= 16'sd16000;
            lgt_x   <= '0;
            lgt_y   <= '0;
            lgt_z   <= -16'sd4096;
            amb_lvl <= 9'd64;
            fail_count <= 0;
            shade_q.delete();
        end else begin
            if (s_tvalid && s_tready) shade_q.insert(shade_q.size(), shade_face(s_tdata));
            if (m_tvalid && m_tready) begin
                got = {m_tuser[0], m_tuser[1], m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]};
                if (shade_q.size() == 0) begin
                    $display("%0t: unexpected result item %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = shade_q.pop_front();
                    if (want !== got) begin
                        $display({"%0t: mismatch exp vis=%b lit=%b rgb=%h/%h/%h",
                                  " got vis=%b lit=%b rgb=%h/%h/%h"},
                                 $time, want.visible, want.lit, want.r, want.g, want.b,
                                 got.visible, got.lit, got.r, got.g, got.b);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_we) begin
                unique case (cfg_addr)
                    fsbc_pkg::CFG_PROJ_Z:  proj_z  <= cfg_wdata;
                    fsbc_pkg::CFG_LIGHT_X: lgt_x   <= cfg_wdata;
                    fsbc_pkg::CFG_LIGHT_Y: lgt_y   <= cfg_wdata;
                    fsbc_pkg::CFG_LIGHT_Z: lgt_z   <= cfg_wdata;
                    fsbc_pkg::CFG_AMBIENT: amb_lvl <= cfg_wdata[8:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

>>> tb/flat_shade_backface_cull_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flat_shade_backface_cull_tb
// Drives triangles through the cull/shade pipeline under several light and
// ambient settings and idling mixes; the checker predicts and compares.
// ----------------------------------------------------------------------------
module flat_shade_backface_cull_tb;

    localparam int LATENCY   = 61;
    localparam int MAX_CYCLE = 600000;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [fsbc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [fsbc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // a0_x .. a2_z (16 each), color_r, color_g, color_b (8 each)
    logic [167:0]                    s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // shade_r, shade_g, shade_b
    logic [23:0]                     m_tdata;
    // visible, lit
    logic [1:0]                      m_tuser;

    int fail_count, pending;
    int send_idle = 0;        // percent of sender idle cycles
    int recv_stall = 0;       // percent of receiver stall cycles
    int hold_len = 0;         // request for a long receiver hold-off
    int hold_left = 0;
    int cycle = 0;

    always #2 aclk = ~aclk;

    flat_shade_backface_cull uut (.*);
    fsbc_checker chk (.*);

    // run limit
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold so the pipe backs up
    always @(posedge aclk) begin
        if (hold_len != 0 && hold_left == 0) begin
            hold_left <= hold_len;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send_tri(logic [167:0] d);
        if (send_idle != 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // hold the input until every expected result is back, then let the pipe empty
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [fsbc_pkg::CFG_ADDR_W-1:0] idx, logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_light(logic [15:0] pz, logic [15:0] lx, logic [15:0] ly,
                             logic [15:0] lz, logic [15:0] amb);
        cfg_write(fsbc_pkg::CFG_PROJ_Z, pz);
        cfg_write(fsbc_pkg::CFG_LIGHT_X, lx);
        cfg_write(fsbc_pkg::CFG_LIGHT_Y, ly);
        cfg_write(fsbc_pkg::CFG_LIGHT_Z, lz);
        cfg_write(fsbc_pkg::CFG_AMBIENT, amb);
    endtask

    function automatic logic [167:0] pack_tri(logic [15:0] c[9], logic [23:0] rgb);
        logic [167:0] d;
        for (int i = 0; i < 9; i++) d[16*i +: 16] = c[i];
        d[167:144] = rgb;
        return d;
    endfunction

    // mostly small, well-shaped triangles so faces split front/back and
    // the cosine spans its range; some full-range, degenerate and extreme ones
    function automatic logic [167:0] rand_tri();
        logic [15:0] c[9];
        int kind;
        int span;
        kind = $urandom_range(9);
        span = (1 << $urandom_range(15, 4)) - 1;
        for (int i = 0; i < 9; i++) begin
            case (kind)
                0, 1:    c[i] = 16'($urandom);
                2:       c[i] = $urandom_range(1) ? 16'h7fff : 16'h8000;
                default: c[i] = 16'($signed($urandom_range(2 * span)) - span);
            endcase
        end
        if (kind == 3) begin            // repeated vertex: zero normal
            c[3] = c[0]; c[4] = c[1]; c[5] = c[2];
        end
        return pack_tri(c, 24'($urandom));
    endfunction

    task automatic run_phase(int n, int idle, int stall);
        send_idle  = idle;
        recv_stall = stall;
        for (int i = 0; i < n; i++) send_tri(rand_tri());
        drain();
    endtask

    initial begin
        logic [15:0] c[9];
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, front/back faces, extremes, degenerate
        c = '{16'd0, 16'd0, 16'd0, 16'd16, 16'd0, 16'd0, 16'd0, 16'd16, 16'd0};
        send_tri(pack_tri(c, 24'hffffff));
        c = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd16, 16'd0, 16'd16, 16'd0, 16'd0};
        send_tri(pack_tri(c, 24'hffffff));
        c = '{default: 16'd0};
        send_tri(pack_tri(c, 24'h123456));
        c = '{default: 16'h7fff};
        send_tri(pack_tri(c, 24'hffffff));
        c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
              16'h8000, 16'h7fff, 16'h8000};
        send_tri(pack_tri(c, 24'hff00ff));
        c = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
              16'h7fff, 16'h8000, 16'h8000};
        send_tri(pack_tri(c, 24'h00ff00));
        c = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
              16'h7fff, 16'h7fff, 16'h8000};
        send_tri(pack_tri(c, 24'hffffff));
        c = '{16'd0, 16'd0, 16'd0, 16'd16, 16'd16, 16'd0, 16'd32, 16'd32, 16'd0};
        send_tri(pack_tri(c, 24'hffffff));   // collinear
        drain();

        // light along +z: the front face above is lit head-on
        set_light(16'd16000, 16'd0, 16'd0, 16'd4096, 16'd256);
        c = '{16'd0, 16'd0, 16'd0, 16'd16, 16'd0, 16'd0, 16'd0, 16'd16, 16'd0};
        send_tri(pack_tri(c, 24'hffffff));
        send_tri(pack_tri(c, 24'h000000));
        drain();
        cfg_write(fsbc_pkg::CFG_AMBIENT, 16'd0);
        send_tri(pack_tri(c, 24'h80ff01));
        drain();
        cfg_write(fsbc_pkg::CFG_AMBIENT, 16'd511);     // saturates to full scale
        send_tri(pack_tri(c, 24'hfe7f01));
        drain();

        // random phases across settings and idling mixes
        set_light(16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'd0);
        run_phase(200, 0, 0);
        set_light(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'd256);
        run_phase(200, 50, 0);
        set_light(16'd0, 16'd0, 16'd0, 16'd0, 16'd128);   // zero light
        run_phase(200, 0, 50);
        set_light(16'd16000, 16'd0, 16'd0, 16'hf000, 16'd64);
        run_phase(200, 14, 14);
        set_light(16'd5, 16'd3, 16'hfff9, 16'd11, 16'd300);
        run_phase(200, 50, 50);

        // back-pressure: long receiver hold while items keep coming
        set_light(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom_range(256)));
        send_idle  = 0;
        recv_stall = 0;
        hold_len   = 400;
        for (int i = 0; i < 150; i++) begin
            send_tri(rand_tri());
            if (i == 10) hold_len = 0;
        end
        drain();

        for (int p = 0; p < 4; p++) begin
            set_light(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom_range(511)));
            run_phase(140, (p == 1) ? 50 : (p == 3 ? 14 : 0),
                      (p == 2) ? 50 : (p == 3 ? 14 : 0));
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
